// File: src/assert_macros.svh
// Assertion macros for the RTL files of the contact slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check, clocked on the rising edge and off while in reset.
`define CSA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// At most one bit of a vector is set, checked at every rising clock edge and off while in reset.
`define CSA_ASSERT_ONEHOT0(name, clk, rst_n, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) else $error(msg);

`endif

// File: src/csa_pkg.sv
package csa_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdW   = 16;
  localparam int unsigned SlotW = 4;

  // Packed widths on the stream ports, rounded up to whole bytes.
  localparam int unsigned STDataW = 16;
  localparam int unsigned STUserW = 8;
  localparam int unsigned MTDataW = 8;
  localparam int unsigned MTUserW = 8;

  // Event kinds; code 3 is unused and handled by default arms.
  typedef enum logic [CmdW-1:0] {
    CMD_ON   = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_OFF  = 2'd2
  } csa_cmd_e;

  // Search status passed from the lookup logic to the table control.
  typedef struct packed {
    logic free_found;
    logic match_found;
  } csa_find_t;

endpackage

// File: src/csa_lookup.sv
module csa_lookup #(
  parameter int unsigned SLOT_COUNT = 10,
  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic [SLOT_COUNT-1:0]    slot_valid_i,
  input  logic [csa_pkg::IdW-1:0]  slot_contact_i [SLOT_COUNT],
  input  logic [csa_pkg::IdW-1:0]  contact_id_i,
  output logic [SLOT_COUNT-1:0]    free_oh_o,
  output logic [SLOT_COUNT-1:0]    match_oh_o,
  output logic [IdxW-1:0]          free_idx_o,
  output logic [IdxW-1:0]          match_idx_o,
  output csa_pkg::csa_find_t       find_o
);
  import csa_pkg::*;

  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] match_vec;

  // One comparator per slot; only occupied slots may match.
  always_comb begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      free_vec[k]  = !slot_valid_i[k];
      match_vec[k] = slot_valid_i[k] && (slot_contact_i[k] == contact_id_i);
    end
  end

  // Keep only the lowest set bit of each candidate vector.
  assign free_oh_o  = free_vec & (~free_vec + SLOT_COUNT'(1));
  assign match_oh_o = match_vec & (~match_vec + SLOT_COUNT'(1));

  // Priority encoders: the lowest candidate is written last and wins.
  always_comb begin
    free_idx_o  = '0;
    match_idx_o = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (free_vec[k]) begin
        free_idx_o = IdxW'(k);
      end
      if (match_vec[k]) begin
        match_idx_o = IdxW'(k);
      end
    end
  end

  assign find_o.free_found  = |free_vec;
  assign find_o.match_found = |match_vec;

endmodule

// File: src/contact_slot_allocator.sv
// Contact slot allocator: a table of SLOT_COUNT contact slots with on, move and off events.
// A request is accepted into the input register and its result is loaded into the result
// register, with the table lookup and update between them. One request per cycle is taken
// while the result register is free or draining; the table is read and written in the same cycle.
// Reset: asynchronous, active low; every slot is marked free at once, no clearing pass.
`include "assert_macros.svh"

module contact_slot_allocator #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [csa_pkg::STDataW-1:0]  s_axis_tdata_i,  // [15:0] contact_id
  input  logic [csa_pkg::STUserW-1:0]  s_axis_tuser_i,  // [1:0] command, [7:2] zero
  // Result stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [csa_pkg::MTDataW-1:0]  m_axis_tdata_o,  // [3:0] slot, [7:4] zero
  output logic [csa_pkg::MTUserW-1:0]  m_axis_tuser_o   // [0] hit, [2:1] event_kind, [7:3] zero
);
  import csa_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Input register.
  logic              in_valid_q, in_valid_d;
  logic [CmdW-1:0]   in_cmd_q, in_cmd_d;
  logic [IdW-1:0]    in_id_q, in_id_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [SlotW-1:0]  out_slot_q, out_slot_d;
  logic              out_hit_q, out_hit_d;
  logic [CmdW-1:0]   out_kind_q, out_kind_d;

  // Slot table.
  logic [SLOT_COUNT-1:0] slot_valid_q, slot_valid_d;
  logic [IdW-1:0]        slot_contact_q [SLOT_COUNT];

  logic                  out_free;
  logic                  advance;
  logic                  process;
  logic [SLOT_COUNT-1:0] free_oh;
  logic [SLOT_COUNT-1:0] match_oh;
  logic [IdxW-1:0]       free_idx;
  logic [IdxW-1:0]       match_idx;
  csa_find_t             find;
  logic [SLOT_COUNT-1:0] set_vec;
  logic [SLOT_COUNT-1:0] clr_vec;
  logic                  hit;
  logic [IdxW-1:0]       hit_idx;
  logic [31:0]           hit_idx_ext;

  // The result register can load when it is empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = out_free;
  assign process  = advance && in_valid_q;

  assign s_axis_tready_o = !in_valid_q || advance;

  csa_lookup #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_lookup (
    .slot_valid_i   (slot_valid_q),
    .slot_contact_i (slot_contact_q),
    .contact_id_i   (in_id_q),
    .free_oh_o      (free_oh),
    .match_oh_o     (match_oh),
    .free_idx_o     (free_idx),
    .match_idx_o    (match_idx),
    .find_o         (find)
  );

  // Decode the event into table set and clear masks and a result.
  always_comb begin
    set_vec = '0;
    clr_vec = '0;
    hit     = 1'b0;
    hit_idx = '0;
    case (in_cmd_q)
      CMD_ON: begin
        hit     = find.free_found;
        hit_idx = free_idx;
        set_vec = free_oh;
      end
      CMD_MOVE: begin
        hit     = find.match_found;
        hit_idx = match_idx;
      end
      CMD_OFF: begin
        hit     = find.match_found;
        hit_idx = match_idx;
        clr_vec = match_oh;
      end
      default: begin
        hit     = 1'b0;
        hit_idx = '0;
      end
    endcase
  end

  assign hit_idx_ext = 32'(hit_idx);

  // Next values of the input register.
  always_comb begin
    in_valid_d = in_valid_q;
    in_cmd_d   = in_cmd_q;
    in_id_d    = in_id_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
      in_cmd_d   = s_axis_tuser_i[CmdW-1:0];
      in_id_d    = s_axis_tdata_i[IdW-1:0];
    end
  end

  // Next values of the result register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_hit_d   = out_hit_q;
    out_kind_d  = out_kind_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      out_slot_d  = hit ? hit_idx_ext[SlotW-1:0] : '0;
      out_hit_d   = hit;
      out_kind_d  = in_cmd_q;
    end
  end

  // Occupancy update for the event being processed.
  always_comb begin
    slot_valid_d = slot_valid_q;
    if (process) begin
      slot_valid_d = (slot_valid_q | set_vec) & ~clr_vec;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      slot_valid_q <= slot_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_cmd_q   <= in_cmd_d;
    in_id_q    <= in_id_d;
    out_slot_q <= out_slot_d;
    out_hit_q  <= out_hit_d;
    out_kind_q <= out_kind_d;
  end

  // Contact ids are stored into the slot that an on event takes.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (process && set_vec[k]) begin
        slot_contact_q[k] <= in_id_q;
      end
    end
  end

  // Output packing.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = MTDataW'(out_slot_q);
  assign m_axis_tuser_o  = MTUserW'({out_kind_q, out_hit_q});

  // The lookup picks at most one slot of each kind.
  `CSA_ASSERT_ONEHOT0(a_free_onehot, clk_i, rst_ni, free_oh, "free slot select is not one-hot")
  `CSA_ASSERT_ONEHOT0(a_match_onehot, clk_i, rst_ni, match_oh, "match select is not one-hot")
  // An allocation adds exactly one occupied slot.
  `CSA_ASSERT(a_on_adds_one, clk_i, rst_ni,
    (process && in_cmd_q == CMD_ON && find.free_found) |=>
    ($countones(slot_valid_q) == $past($countones(slot_valid_q)) + 1),
    "on event did not occupy one slot")
  // A removal frees exactly one slot.
  `CSA_ASSERT(a_off_frees_one, clk_i, rst_ni,
    (process && in_cmd_q == CMD_OFF && find.match_found) |=>
    ($countones(slot_valid_q) + 1 == $past($countones(slot_valid_q))),
    "off event did not free one slot")
  // A move never changes occupancy.
  `CSA_ASSERT(a_move_keeps, clk_i, rst_ni,
    (process && in_cmd_q == CMD_MOVE) |=> $stable(slot_valid_q),
    "move event changed the slot table")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import csa_pkg::*;

  localparam int unsigned SlotCount = 10;
  // Command code 3 carries no event; the block only echoes it.
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;

  localparam int unsigned RandomEvents  = 1230;
  localparam int unsigned IdleChance    = 28;
  localparam int unsigned CalmFirst     = 600;
  localparam int unsigned CalmLast      = 850;
  localparam int unsigned HoldOffAt     = 400;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned DrainAt       = 700;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned ReportMax     = 10;

  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0]  id;
    bit              wait_drain;
  } contact_event_t;

  typedef struct {
    logic [SlotW-1:0] slot;
    logic             hit;
    logic [CmdW-1:0]  kind;
  } slot_report_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic [STDataW-1:0]  s_axis_tdata_i  = '0;
  logic [STUserW-1:0]  s_axis_tuser_i  = '0;
  logic                m_axis_tready_i = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [MTDataW-1:0]  m_axis_tdata_o;
  logic [MTUserW-1:0]  m_axis_tuser_o;

  contact_event_t      event_queue[$];
  slot_report_t        report_queue[$];
  logic [IdW-1:0]      live_ids[$];

  // Shadow copy of the slot table.
  bit                  slot_busy[SlotCount];
  bit [IdW-1:0]        slot_owner[SlotCount];

  int unsigned         requests_sent = 0;
  int unsigned         reports_seen  = 0;
  int unsigned         error_count   = 0;
  int unsigned         hold_left     = 0;
  bit                  hold_done     = 1'b0;
  int unsigned         quiet_cycles  = 0;
  logic                calm;

  assign calm = (requests_sent >= CalmFirst) && (requests_sent < CalmLast);

  contact_slot_allocator #(
    .SLOT_COUNT(SlotCount)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the report it should produce.
  function automatic slot_report_t apply_event(logic [CmdW-1:0] cmd, logic [IdW-1:0] id);
    slot_report_t rep;
    int           found;
    found = -1;
    case (cmd)
      CMD_ON: begin
        for (int k = SlotCount - 1; k >= 0; k--) if (!slot_busy[k]) found = k;
        if (found >= 0) begin
          slot_busy[found]  = 1'b1;
          slot_owner[found] = id;
        end
      end
      CMD_MOVE, CMD_OFF: begin
        // Only occupied slots take part in the search; the lowest match wins.
        for (int k = SlotCount - 1; k >= 0; k--) begin
          if (slot_busy[k] && slot_owner[k] == id) found = k;
        end
        if (found >= 0 && cmd == CMD_OFF) begin
          slot_busy[found]  = 1'b0;
          slot_owner[found] = '0;
        end
      end
      default: ;
    endcase
    rep.slot = (found >= 0) ? SlotW'(found) : '0;
    rep.hit  = (found >= 0);
    rep.kind = cmd;
    return rep;
  endfunction

  // Ids come from a small pool half the time so that searches often collide.
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 1) == 0) return IdW'($urandom_range(0, 15));
    return IdW'($urandom_range(0, 16'hFFFF));
  endfunction

  // Queues one request and tracks which ids are held, to shape later requests.
  task automatic queue_event(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                             input bit wait_drain);
    contact_event_t ev;
    int             pos;
    ev.cmd        = cmd;
    ev.id         = id;
    ev.wait_drain = wait_drain;
    event_queue.push_back(ev);
    pos = -1;
    if (cmd == CMD_ON && live_ids.size() < SlotCount) begin
      live_ids.push_back(id);
    end else if (cmd == CMD_OFF) begin
      for (int k = live_ids.size() - 1; k >= 0; k--) if (live_ids[k] == id) pos = k;
      if (pos >= 0) live_ids.delete(pos);
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= ReportMax) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Request driver: valid stays up until the request is taken.
  always @(posedge clk_i) begin : request_driver
    contact_event_t     head;
    logic               next_valid;
    logic [STDataW-1:0] next_data;
    logic [STUserW-1:0] next_user;
    bit                 offer;
    next_valid = s_axis_tvalid_i;
    next_data  = s_axis_tdata_i;
    next_user  = s_axis_tuser_i;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) next_valid = 1'b0;
      if (!next_valid && event_queue.size() > 0) begin
        offer = calm || ($urandom_range(0, 99) >= IdleChance);
        // A marked request waits until every outstanding result is back,
        // including the one for a request taken at this very edge.
        if (event_queue[0].wait_drain &&
            (report_queue.size() != 0 || s_axis_tvalid_i)) offer = 1'b0;
        if (offer) begin
          head       = event_queue.pop_front();
          next_valid = 1'b1;
          next_data  = STDataW'(head.id);
          next_user  = STUserW'(head.cmd);
        end
      end
    end
    s_axis_tvalid_i <= next_valid;
    s_axis_tdata_i  <= next_data;
    s_axis_tuser_i  <= next_user;
  end

  // Result ready, with one long hold-off so that the block backs up.
  always @(posedge clk_i) begin : result_ready
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && reports_seen >= HoldOffAt) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= IdleChance);
      end
    end
  end

  // Monitor: checks each result against the oldest expectation, then predicts new requests.
  always @(posedge clk_i) begin : result_monitor
    slot_report_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        reports_seen++;
        if (report_queue.size() == 0) begin
          note_mismatch("result with no request pending", 0, 1);
        end else begin
          want = report_queue.pop_front();
          if (m_axis_tdata_o[SlotW-1:0] !== want.slot) begin
            note_mismatch("slot", want.slot, m_axis_tdata_o[SlotW-1:0]);
          end
          if (m_axis_tuser_o[0] !== want.hit) begin
            note_mismatch("hit", want.hit, m_axis_tuser_o[0]);
          end
          if (m_axis_tuser_o[CmdW:1] !== want.kind) begin
            note_mismatch("event_kind", want.kind, m_axis_tuser_o[CmdW:1]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        report_queue.push_back(apply_event(s_axis_tuser_i[CmdW-1:0], s_axis_tdata_i[IdW-1:0]));
        requests_sent++;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0]  id;
    bit              filling;
    bit              known;
    int unsigned     roll;
    int unsigned     on_weight;

    // Extreme ids, a repeated id, a search that must skip a freed slot.
    queue_event(CMD_ON, 16'h0000, 1'b0);
    queue_event(CMD_ON, 16'hFFFF, 1'b0);
    queue_event(CMD_ON, 16'hFFFF, 1'b0);
    queue_event(CMD_MOVE, 16'hFFFF, 1'b0);
    queue_event(CMD_OFF, 16'h0000, 1'b0);
    queue_event(CMD_MOVE, 16'h0000, 1'b0);
    queue_event(CMD_OFF, 16'h0000, 1'b0);
    queue_event(CMD_ON, 16'h5555, 1'b0);
    // Fill the table, then try once more while it is full.
    for (int k = 0; k < 7; k++) queue_event(CMD_ON, IdW'(1 << (k + 8)), 1'b0);
    queue_event(CMD_ON, 16'h1234, 1'b0);
    queue_event(CMD_MOVE, 16'h1234, 1'b0);
    queue_event(CmdSpare, 16'hAAAA, 1'b0);
    queue_event(CMD_OFF, 16'hFFFF, 1'b0);
    queue_event(CMD_OFF, 16'hFFFF, 1'b0);
    queue_event(CMD_ON, 16'h0000, 1'b0);
    queue_event(CMD_MOVE, 16'h0000, 1'b0);
    queue_event(CmdSpare, 16'hFFFF, 1'b0);
    queue_event(CMD_MOVE, 16'h5555, 1'b0);

    // Random part: the table is filled and emptied in turns.
    filling = 1'b1;
    for (int n = 0; n < RandomEvents; n++) begin
      if (live_ids.size() == 0) filling = 1'b1;
      else if (live_ids.size() >= SlotCount && $urandom_range(0, 3) == 0) filling = 1'b0;
      on_weight = filling ? 50 : 15;
      roll  = $urandom_range(0, 99);
      known = (live_ids.size() > 0) && ($urandom_range(0, 99) < 80);
      id    = known ? live_ids[$urandom_range(0, live_ids.size() - 1)] : pick_id();
      if (roll < on_weight) begin
        cmd = CMD_ON;
        if (!known || $urandom_range(0, 9) != 0) id = pick_id();
      end else if (roll < on_weight + 20) begin
        cmd = CMD_MOVE;
      end else if (roll < 95) begin
        cmd = CMD_OFF;
      end else begin
        cmd = CmdSpare;
      end
      queue_event(cmd, id, (n == 0) || (n == DrainAt));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (event_queue.size() != 0 || s_axis_tvalid_i || report_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (report_queue.size() != 0) note_mismatch("results never arrived", 0, report_queue.size());

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: contact_slot_allocator.f
+incdir+src
src/csa_pkg.sv
src/csa_lookup.sv
src/contact_slot_allocator.sv
tb/tb.sv
